// File: rtl/adrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adrb_pkg
// shared types, register indexes and constants of the adr backoff controller
// ----------------------------------------------------------------------------
package adrb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_ADR_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ACK_LIMIT     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ACK_DELAY     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_POWER = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_SF    = 3'd4;

  // event kinds
  localparam logic OP_UPLINK   = 1'b0;
  localparam logic OP_DOWNLINK = 1'b1;

  localparam logic [4:0] PWR_STEP_LIMIT = 5'd14;
  localparam logic [4:0] PWR_STEP       = 5'd3;
  localparam logic [3:0] SF_MAX         = 4'd12;

  // reset values
  localparam logic       RST_ADR_ENABLE    = 1'b1;
  localparam logic [7:0] RST_ACK_LIMIT     = 8'd64;
  localparam logic [7:0] RST_ACK_DELAY     = 8'd32;
  localparam logic [4:0] RST_INITIAL_POWER = 5'd14;
  localparam logic [3:0] RST_INITIAL_SF    = 4'd12;

  typedef struct packed {
    logic       adr_enable;
    logic [7:0] ack_limit;
    logic [7:0] ack_delay;
  } cfg_t;

  typedef struct packed {
    logic       pwr_load;
    logic [4:0] pwr_val;
    logic       sf_load;
    logic [3:0] sf_val;
  } load_t;

  typedef struct packed {
    logic [4:0] tx_power;
    logic [3:0] spread_factor;
    logic [8:0] uplink_count;
    logic       request_pending;
  } state_t;

  typedef struct packed {
    logic              opcode;
    logic              is_tx_config;
    logic signed [5:0] cmd_power;
    logic signed [4:0] cmd_sf;
  } item_t;

  typedef struct packed {
    logic       ack_request;
    logic [4:0] power_used;
    logic [3:0] sf_used;
  } result_t;

  function automatic logic [3:0] clamp_sf(input logic [3:0] v);
    return (v > SF_MAX) ? SF_MAX : v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/adrb_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adrb_cfg
// configuration registers and load strobes for power and spreading factor
// ----------------------------------------------------------------------------
module adrb_cfg import adrb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o,
  output load_t                    load_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ADR_ENABLE: cfg_d.adr_enable = cfg_wdata_i[0];
        REG_ACK_LIMIT:  cfg_d.ack_limit  = cfg_wdata_i;
        REG_ACK_DELAY:  cfg_d.ack_delay  = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adr_enable <= RST_ADR_ENABLE;
      cfg_q.ack_limit  <= RST_ACK_LIMIT;
      cfg_q.ack_delay  <= RST_ACK_DELAY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // initial power and sf writes go straight into the live state
  always_comb begin
    load_o.pwr_load = cfg_we_i && (cfg_idx_i == REG_INITIAL_POWER);
    load_o.pwr_val  = cfg_wdata_i[4:0];
    load_o.sf_load  = cfg_we_i && (cfg_idx_i == REG_INITIAL_SF);
    load_o.sf_val   = clamp_sf(cfg_wdata_i[3:0]);
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/adrb_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adrb_core
// single-pass event logic: next backoff state and the result of one event
// ----------------------------------------------------------------------------
module adrb_core import adrb_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t res_o
);

  logic [8:0] cnt_inc;
  logic [8:0] cnt_top;

  assign cnt_inc = state_i.uplink_count + 9'd1;
  assign cnt_top = {1'b0, cfg_i.ack_limit} + {1'b0, cfg_i.ack_delay};

  always_comb begin
    state_o = state_i;
    res_o.ack_request = 1'b0;
    res_o.power_used  = state_i.tx_power;
    res_o.sf_used     = state_i.spread_factor;
    if (item_i.opcode == OP_UPLINK) begin
      if (cfg_i.adr_enable) begin
        res_o.ack_request       = state_i.request_pending;
        state_o.request_pending = 1'b0;
        state_o.uplink_count    = cnt_inc;
        if (cnt_inc == {1'b0, cfg_i.ack_limit}) begin
          state_o.request_pending = 1'b1;
        end
        if (cnt_inc >= cnt_top) begin
          state_o.uplink_count = '0;
          if (state_i.tx_power < PWR_STEP_LIMIT) begin
            state_o.tx_power = state_i.tx_power + PWR_STEP;
          end else if (state_i.spread_factor < SF_MAX) begin
            state_o.spread_factor = state_i.spread_factor + 4'd1;
          end
        end
      end
    end else begin
      if (cfg_i.adr_enable) begin
        state_o.uplink_count = '0;
        if (item_i.is_tx_config) begin
          // a negative value keeps the current setting
          if (!item_i.cmd_power[5]) begin
            state_o.tx_power = item_i.cmd_power[4:0];
          end
          if (!item_i.cmd_sf[4]) begin
            state_o.spread_factor = clamp_sf(item_i.cmd_sf[3:0]);
          end
        end
      end
      res_o.power_used = state_o.tx_power;
      res_o.sf_used    = state_o.spread_factor;
    end
  end

endmodule
`default_nettype wire

// File: rtl/adr_backoff_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adr_backoff_controller
// node-side adaptive data rate backoff: power / spreading factor stepping
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         tuser: opcode, is_tx_config; tdata: cmd_power, cmd_sf
//  m_axis    out        tdata: ack_request, power_used, sf_used
//  cfg       in         write enable, register index, 8-bit write data
//
// one event per cycle while the output side is not stalled: an input register
// feeds the event logic, whose result lands in the output register while the
// state registers update
// the output register decouples the sides: a new event is taken while a
// result waits, and tready drops only when both registers are full
// reset clears both registers' valid flags and loads the default settings
// configuration writes are taken in any cycle, at once
// ----------------------------------------------------------------------------
module adr_backoff_controller import adrb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // slave stream
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [15:0]         s_axis_tdata,  // [5:0] cmd_power, [10:6] cmd_sf
  input  wire logic [1:0]          s_axis_tuser,  // [0] opcode, [1] is_tx_config
  // master stream
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [15:0]         m_axis_tdata,  // [0] ack_request, [5:1] power_used,
                                                  // [9:6] sf_used
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  load_t   load;
  state_t  state_q, state_d, state_nxt;
  item_t   item_q, item_d;
  result_t res_q, res_d;
  logic    in_vld_q, in_vld_d;
  logic    out_vld_q, out_vld_d;
  logic    s_acc;
  logic    advance;

  adrb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .load_o      (load)
  );

  adrb_core u_core (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_nxt),
    .res_o   (res_d)
  );

  // the event in the input register moves on when the output register is
  // empty or being drained this cycle
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.opcode       = s_axis_tuser[0];
    item_d.is_tx_config = s_axis_tuser[1];
    item_d.cmd_power    = s_axis_tdata[5:0];
    item_d.cmd_sf       = s_axis_tdata[10:6];
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = advance ? in_vld_q : out_vld_q;
  end

  // state commits per processed event; loads win; user loads while idle, unchecked
  always_comb begin
    state_d = state_q;
    if (in_vld_q && advance) begin
      state_d = state_nxt;
    end
    if (load.pwr_load) begin
      state_d.tx_power = load.pwr_val;
    end
    if (load.sf_load) begin
      state_d.spread_factor = load.sf_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q                <= 1'b0;
      out_vld_q               <= 1'b0;
      state_q.tx_power        <= RST_INITIAL_POWER;
      state_q.spread_factor   <= RST_INITIAL_SF;
      state_q.uplink_count    <= '0;
      state_q.request_pending <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q <= item_d;
    end
    if (in_vld_q && advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, res_q.sf_used, res_q.power_used, res_q.ack_request};

endmodule
`default_nettype wire

// File: rtl/adrb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adrb_checker
// port-level checks of the adr backoff controller, bound to the top level
// ----------------------------------------------------------------------------
module adrb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input backpressure only when the output side is full and stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // an event taken while the output is empty shows up via the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted event");

  // spreading factor never leaves its range
  a_sf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9:6] <= 4'd12)
    else $error("spreading factor above maximum");

endmodule

bind adr_backoff_controller adrb_checker u_adrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: bench/adr_backoff_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_backoff_controller_test
// self-checking bench: streams uplink / downlink events through the block and
// compares every report against an in-bench model of the backoff state
// ----------------------------------------------------------------------------
module adr_backoff_controller_test;
  import adrb_pkg::*;

  localparam int unsigned PhaseItems = 42;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;   // [5:0] cmd_power, [10:6] cmd_sf
  logic [1:0]          s_axis_tuser;   // [0] opcode, [1] is_tx_config
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [0] ack_request, [5:1] power_used, [9:6] sf_used
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // events waiting to be driven, and reports the model says are on their way
  item_t   event_q[$];
  result_t adr_reports_q[$];

  // model copy of the settings and of the backoff state
  logic       r_enable = RST_ADR_ENABLE;
  logic [7:0] r_limit  = RST_ACK_LIMIT;
  logic [7:0] r_delay  = RST_ACK_DELAY;
  logic [4:0] m_power  = RST_INITIAL_POWER;
  logic [3:0] m_sf     = RST_INITIAL_SF;
  logic [8:0] m_count  = '0;
  logic       m_pending = 1'b0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  events_queued  = 0;
  int  events_taken   = 0;
  int  mismatch_cnt   = 0;
  bit  item_taken     = 1'b0;

  adr_backoff_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one event through the backoff state; returns the report it causes
  function automatic result_t step_backoff(input item_t ev);
    result_t rep;
    rep = '0;
    if (ev.opcode == OP_UPLINK) begin
      // uplink reports the settings it was sent with, then gets counted when enabled
      rep.power_used = m_power;
      rep.sf_used    = m_sf;
      if (r_enable) begin
        if (m_pending) begin
          rep.ack_request = 1'b1;
          m_pending = 1'b0;
        end
        m_count = m_count + 9'd1;
        if (m_count == {1'b0, r_limit}) m_pending = 1'b1;
        // limit plus delay reached: back off, power first, then sf
        if (int'(m_count) >= int'(r_limit) + int'(r_delay)) begin
          m_count = '0;
          if (m_power < PWR_STEP_LIMIT) m_power = m_power + PWR_STEP;
          else if (m_sf < SF_MAX) m_sf = m_sf + 4'd1;
        end
      end
    end else begin
      // downlink clears the count when enabled; tx-config overrides unless negative
      if (r_enable) begin
        m_count = '0;
        if (ev.is_tx_config) begin
          if (!ev.cmd_power[5]) m_power = ev.cmd_power[4:0];
          if (!ev.cmd_sf[4]) m_sf = (ev.cmd_sf[3:0] > SF_MAX) ? SF_MAX : ev.cmd_sf[3:0];
        end
      end
      rep.power_used = m_power;
      rep.sf_used    = m_sf;
    end
    return rep;
  endfunction

  // register write, mirrored into the model (only called while the block idles)
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    logic [CfgDataW-1:0] v;
    v = CfgDataW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    case (idx)
      REG_ADR_ENABLE:    r_enable = v[0];
      REG_ACK_LIMIT:     r_limit  = v;
      REG_ACK_DELAY:     r_delay  = v;
      REG_INITIAL_POWER: m_power  = v[4:0];
      REG_INITIAL_SF:    m_sf     = (v[3:0] > SF_MAX) ? SF_MAX : v[3:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // every queued event taken and every report back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (events_taken != events_queued || adr_reports_q.size() != 0);
  endtask

  task automatic queue_event(input logic op, input logic txcfg,
                             input logic signed [5:0] pwr, input logic signed [4:0] sf);
    item_t ev;
    ev.opcode       = op;
    ev.is_tx_config = txcfg;
    ev.cmd_power    = pwr;
    ev.cmd_sf       = sf;
    event_q.push_back(ev);
    events_queued++;
  endtask

  function automatic item_t random_event(input int uplink_pct);
    item_t ev;
    ev.opcode       = ($urandom_range(0, 99) < uplink_pct) ? OP_UPLINK : OP_DOWNLINK;
    ev.is_tx_config = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       ev.cmd_power = -6'sd1;
      1:       ev.cmd_power = 6'($urandom);
      default: ev.cmd_power = 6'($urandom_range(0, 31));
    endcase
    case ($urandom_range(0, 3))
      0:       ev.cmd_sf = -5'sd1;
      1:       ev.cmd_sf = 5'($urandom);
      default: ev.cmd_sf = 5'($urandom_range(0, 12));
    endcase
    return ev;
  endfunction

  // settings for one phase, then a batch of random events
  task automatic run_phase(input int en, input int lim, input int del, input int pwr,
                           input int sf, input int uplink_pct, input int mode);
    wait_idle();
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
    write_reg(REG_ADR_ENABLE, en);
    write_reg(REG_ACK_LIMIT, lim);
    write_reg(REG_ACK_DELAY, del);
    write_reg(REG_INITIAL_POWER, pwr);
    write_reg(REG_INITIAL_SF, sf);
    end_writes();
    for (int i = 0; i < PhaseItems; i++) begin
      event_q.push_back(random_event(uplink_pct));
      events_queued++;
    end
  endtask

  // stimulus: reset, directed events, then randomized phases
  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // default settings: plain and tx-config downlinks, keep markers, saturation
    queue_event(OP_UPLINK,   1'b0, 6'sd0,   5'sd0);
    queue_event(OP_DOWNLINK, 1'b0, 6'sd5,   5'sd7);
    queue_event(OP_DOWNLINK, 1'b1, -6'sd1,  -5'sd1);
    queue_event(OP_DOWNLINK, 1'b1, 6'sd31,  5'sd12);
    queue_event(OP_UPLINK,   1'b0, 6'sd0,   5'sd0);
    queue_event(OP_DOWNLINK, 1'b1, 6'sd0,   5'sd15);
    queue_event(OP_DOWNLINK, 1'b1, -6'sd32, -5'sd16);
    queue_event(OP_DOWNLINK, 1'b1, 6'sd13,  5'sd13);
    queue_event(OP_UPLINK,   1'b1, 6'sd2,   5'sd2);
    queue_event(OP_UPLINK,   1'b0, -6'sd1,  -5'sd1);

    // tight window: ack request and backoff every second uplink
    wait_idle();
    write_reg(REG_ACK_LIMIT, 1);
    write_reg(REG_ACK_DELAY, 1);
    write_reg(REG_INITIAL_POWER, 0);
    write_reg(REG_INITIAL_SF, 7);
    end_writes();
    repeat (9) queue_event(OP_UPLINK, 1'b0, 6'sd0, 5'sd0);

    // adr disabled: nothing moves, pending request stays put
    wait_idle();
    write_reg(REG_ADR_ENABLE, 0);
    end_writes();
    queue_event(OP_UPLINK,   1'b0, 6'sd0,  5'sd0);
    queue_event(OP_DOWNLINK, 1'b1, 6'sd20, 5'sd8);
    queue_event(OP_UPLINK,   1'b0, 6'sd0,  5'sd0);

    run_phase(1, 1,   1,   0,  7,  80, 0);
    run_phase(1, 3,   2,   13, 11, 80, 1);
    run_phase(1, 0,   1,   31, 15, 80, 2);
    run_phase(1, 255, 255, 14, 12, 80, 3);
    run_phase(0, 2,   2,   5,  9,  70, 0);
    run_phase(1, 0,   0,   1,  0,  80, 1);
    for (int p = 0; p < 3; p++) begin
      run_phase(1, $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 31),
                $urandom_range(0, 15), (p == 2) ? 50 : 85, p + 1);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && adr_reports_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // driver: present the next event once the previous transaction is done
  always @(negedge clk_i) begin
    item_t ev;
    if (rst_ni) begin
      if (!s_axis_tvalid || item_taken) begin
        item_taken = 1'b0;
        if (event_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          ev = event_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, ev.cmd_sf, ev.cmd_power};
          s_axis_tuser  <= {ev.is_tx_config, ev.opcode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    item_t   ev;
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        ev.opcode       = s_axis_tuser[0];
        ev.is_tx_config = s_axis_tuser[1];
        ev.cmd_power    = s_axis_tdata[5:0];
        ev.cmd_sf       = s_axis_tdata[10:6];
        adr_reports_q.push_back(step_backoff(ev));
        item_taken = 1'b1;
        events_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (adr_reports_q.size() == 0) begin
          $error("report with none outstanding: tdata %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = adr_reports_q.pop_front();
          if (m_axis_tdata[0] !== want.ack_request) begin
            $error("ack_request: expected %0d, got %0d", want.ack_request, m_axis_tdata[0]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[5:1] !== want.power_used) begin
            $error("power_used: expected %0d, got %0d", want.power_used, m_axis_tdata[5:1]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[9:6] !== want.sf_used) begin
            $error("sf_used: expected %0d, got %0d", want.sf_used, m_axis_tdata[9:6]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
